// ===== src/pblct_pkg.sv =====
// Shared types and constants for the per-bucket linked chain table.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package pblct_pkg;

  localparam int FUNC_W     = 2;
  localparam int TILE_W     = 16;
  localparam int ID_W       = 10;
  localparam int POS_W      = 5;
  localparam int IN_DATA_W  = 32;   // tile + object_id, padded to whole bytes
  localparam int OUT_DATA_W = 16;   // position + head_id + occupied

  // positions saturate here
  localparam logic [POS_W-1:0] POSITION_CAP = 5'd20;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_FIND   = 2'd1,
    FN_DELETE = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {CUR_HOLD, CUR_HEAD, CUR_LINK} cur_sel_t;
  typedef enum logic [1:0] {POS_HOLD, POS_CLR, POS_ONE, POS_INC} pos_op_t;
  typedef enum logic [1:0] {N_HOLD, N_CLR, N_INC} n_op_t;
  typedef enum logic [1:0] {HQ_HOLD, HQ_RDATA, HQ_ID, HQ_LINK} hq_sel_t;
  typedef enum logic {LA_ID, LA_CUR} link_wa_t;
  typedef enum logic [1:0] {LD_ZERO, LD_ID, LD_LINK} link_wd_t;
  typedef enum logic {HW_ID, HW_LINK} head_wd_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     clr_wr;
    logic     head_we;
    head_wd_t head_wd;
    logic     link_we;
    link_wa_t link_wa;
    link_wd_t link_wd;
    logic     raddr_id;
    cur_sel_t cur_sel;
    hq_sel_t  hq_sel;
    pos_op_t  pos_op;
    n_op_t    n_op;
    logic     push;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  clr_last;
    logic  tile_ok;
    func_t func;
    logic  head_zero;
    logic  head_eq_id;
    logic  id_zero;
    logic  link_zero;
    logic  link_eq_id;
    logic  cur_zero;
    logic  cur_eq_id;
    logic  n_full;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/pblct_datapath.sv =====
// Datapath: head and link memories, walk registers, output register.
// Driven by pblct_ctrl through pblct_pkg::cmd_t; reports pblct_pkg::sts_t.
`default_nettype none

module pblct_datapath #(
  parameter int TILE_COUNT   = 32768,
  parameter int OBJECT_SLOTS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pblct_pkg::cmd_t                     cmd,
  output pblct_pkg::sts_t                          sts,
  input  wire logic [pblct_pkg::IN_DATA_W-1:0]     in_data,
  input  wire logic [pblct_pkg::FUNC_W-1:0]        in_user,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [pblct_pkg::OUT_DATA_W-1:0]         out_data,
  output logic                                     out_user
);

  localparam int HEAD_AW   = $clog2(TILE_COUNT);
  localparam int OBJ_AW    = $clog2(OBJECT_SLOTS);
  localparam int CLR_DEPTH = (TILE_COUNT > OBJECT_SLOTS) ? TILE_COUNT : OBJECT_SLOTS;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);
  localparam int N_W       = $clog2(OBJECT_SLOTS + 1);
  localparam int TW        = pblct_pkg::TILE_W;
  localparam int IW        = pblct_pkg::ID_W;

  pblct_pkg::func_t               func_q;
  logic [TW-1:0]                  tile_q;
  logic [IW-1:0]                  id_q;
  logic [IW-1:0]                  head_rdata;
  logic [IW-1:0]                  link_rdata;
  logic [IW-1:0]                  cur;
  logic [IW-1:0]                  head_q;
  logic [pblct_pkg::POS_W-1:0]    pos;
  logic [N_W-1:0]                 n;
  logic [CLR_AW-1:0]              clr_cnt;

  logic [TW-1:0]                  tile_in;
  logic [IW-1:0]                  id_in;
  logic [IW-1:0]                  id_clean;
  logic                           tile_ok;
  logic [HEAD_AW-1:0]             tile_idx;
  logic [IW-1:0]                  raddr;
  logic [IW-1:0]                  link_waddr;
  logic [IW-1:0]                  link_wdata;
  logic [IW-1:0]                  head_wdata;
  logic                           clr_in_head;
  logic                           clr_in_link;

  logic [IW-1:0] head_mem [TILE_COUNT];
  logic [IW-1:0] link_mem [OBJECT_SLOTS];

  assign tile_in  = in_data[TW-1:0];
  assign id_in    = in_data[TW+IW-1:TW];
  // ids beyond the slot range mean "none"
  assign id_clean = ({1'b0, id_in} < (IW+1)'(OBJECT_SLOTS)) ? id_in : '0;

  assign tile_ok  = ({1'b0, tile_q} < (TW+1)'(TILE_COUNT));
  assign tile_idx = tile_q[HEAD_AW-1:0];
  assign raddr    = cmd.raddr_id ? id_q : cur;

  assign clr_in_head = ({1'b0, clr_cnt} < (CLR_AW+1)'(TILE_COUNT));
  assign clr_in_link = ({1'b0, clr_cnt} < (CLR_AW+1)'(OBJECT_SLOTS));

  assign head_wdata = (cmd.head_wd == pblct_pkg::HW_LINK) ? link_rdata : id_q;
  assign link_waddr = (cmd.link_wa == pblct_pkg::LA_CUR) ? cur : id_q;

  always_comb begin
    case (cmd.link_wd)
      pblct_pkg::LD_ID:   link_wdata = id_q;
      pblct_pkg::LD_LINK: link_wdata = link_rdata;
      default:            link_wdata = '0;
    endcase
  end

  // head table: one write port, one registered read port at the item's tile
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      if (clr_in_head) head_mem[clr_cnt[HEAD_AW-1:0]] <= '0;
    end else if (cmd.head_we) begin
      head_mem[tile_idx] <= head_wdata;
    end
    head_rdata <= head_mem[tile_idx];
  end

  // link table: one write port, one registered read port at cur or id
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      if (clr_in_link) link_mem[clr_cnt[OBJ_AW-1:0]] <= '0;
    end else if (cmd.link_we) begin
      link_mem[link_waddr[OBJ_AW-1:0]] <= link_wdata;
    end
    link_rdata <= link_mem[raddr[OBJ_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= pblct_pkg::func_t'(in_user);
      tile_q <= tile_in;
      id_q   <= id_clean;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.cur_sel)
      pblct_pkg::CUR_HEAD: cur <= head_rdata;
      pblct_pkg::CUR_LINK: cur <= link_rdata;
      default:             cur <= cur;
    endcase

    case (cmd.hq_sel)
      pblct_pkg::HQ_RDATA: head_q <= head_rdata;
      pblct_pkg::HQ_ID:    head_q <= id_q;
      pblct_pkg::HQ_LINK:  head_q <= link_rdata;
      default:             head_q <= head_q;
    endcase

    case (cmd.pos_op)
      pblct_pkg::POS_CLR: pos <= '0;
      pblct_pkg::POS_ONE: pos <= pblct_pkg::POS_W'(1);
      pblct_pkg::POS_INC: pos <= (pos >= pblct_pkg::POSITION_CAP) ?
                                 pblct_pkg::POSITION_CAP : pos + 1'b1;
      default:            pos <= pos;
    endcase

    case (cmd.n_op)
      pblct_pkg::N_CLR: n <= '0;
      pblct_pkg::N_INC: n <= n + 1'b1;
      default:          n <= n;
    endcase
  end

  // result register; frees up as soon as the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (tile_ok) begin
        out_data <= {(head_q != '0), head_q, pos};
        out_user <= 1'b0;
      end else begin
        out_data <= '0;
        out_user <= 1'b1;
      end
    end
  end

  assign sts.clr_last   = (clr_cnt == CLR_AW'(CLR_DEPTH - 1));
  assign sts.tile_ok    = tile_ok;
  assign sts.func       = func_q;
  assign sts.head_zero  = (head_rdata == '0);
  assign sts.head_eq_id = (head_rdata == id_q);
  assign sts.id_zero    = (id_q == '0);
  assign sts.link_zero  = (link_rdata == '0);
  assign sts.link_eq_id = (link_rdata == id_q);
  assign sts.cur_zero   = (cur == '0);
  assign sts.cur_eq_id  = (cur == id_q);
  assign sts.n_full     = (n == N_W'(OBJECT_SLOTS));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== src/pblct_ctrl.sv =====
// Controller state machine: clearing pass, operation dispatch, chain walks.
// Depends on pblct_pkg for the command and status structs.
`default_nettype none

module pblct_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pblct_pkg::sts_t  sts,
  output pblct_pkg::cmd_t       cmd
);

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_CHECK    = 16'h0004,
    S_HEAD     = 16'h0008,
    S_ADD_RD   = 16'h0010,
    S_ADD_CHK  = 16'h0020,
    S_FIND_CHK = 16'h0040,
    S_FIND_LD  = 16'h0080,
    S_DEL_HRD  = 16'h0100,
    S_DEL_HWR  = 16'h0200,
    S_DEL_RD   = 16'h0400,
    S_DEL_CHK  = 16'h0800,
    S_DEL_IDRD = 16'h1000,
    S_DEL_FIX  = 16'h2000,
    S_DEL_CLR  = 16'h4000,
    S_FIN      = 16'h8000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      // head read at the latched tile lands during S_HEAD
      S_CHECK: begin
        state_next = sts.tile_ok ? S_HEAD : S_FIN;
      end
      S_HEAD: begin
        cmd.cur_sel = pblct_pkg::CUR_HEAD;
        cmd.n_op    = pblct_pkg::N_CLR;
        cmd.pos_op  = pblct_pkg::POS_CLR;
        cmd.hq_sel  = pblct_pkg::HQ_RDATA;
        unique case (sts.func)
          pblct_pkg::FN_ADD: begin
            // object's own link is cleared before the walk
            cmd.link_we = 1'b1;
            cmd.link_wa = pblct_pkg::LA_ID;
            cmd.link_wd = pblct_pkg::LD_ZERO;
            if (sts.head_zero) begin
              cmd.head_we = 1'b1;
              cmd.head_wd = pblct_pkg::HW_ID;
              cmd.hq_sel  = pblct_pkg::HQ_ID;
              state_next  = S_FIN;
            end else begin
              cmd.pos_op = pblct_pkg::POS_ONE;
              state_next = S_ADD_RD;
            end
          end
          pblct_pkg::FN_FIND: begin
            state_next = S_FIND_CHK;
          end
          pblct_pkg::FN_DELETE: begin
            if (sts.head_zero || sts.id_zero) begin
              state_next = S_FIN;
            end else if (sts.head_eq_id) begin
              state_next = S_DEL_HRD;
            end else begin
              state_next = S_DEL_RD;
            end
          end
          pblct_pkg::FN_QUERY: begin
            state_next = S_FIN;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_ADD_RD: begin
        state_next = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        if (sts.link_zero || sts.n_full) begin
          cmd.link_we = 1'b1;
          cmd.link_wa = pblct_pkg::LA_CUR;
          cmd.link_wd = pblct_pkg::LD_ID;
          state_next  = S_FIN;
        end else begin
          cmd.cur_sel = pblct_pkg::CUR_LINK;
          cmd.n_op    = pblct_pkg::N_INC;
          cmd.pos_op  = pblct_pkg::POS_INC;
          state_next  = S_ADD_RD;
        end
      end
      // link of cur is read while this state holds
      S_FIND_CHK: begin
        if (sts.n_full || sts.cur_zero || sts.cur_eq_id) begin
          state_next = S_FIN;
        end else begin
          cmd.n_op   = pblct_pkg::N_INC;
          cmd.pos_op = pblct_pkg::POS_INC;
          state_next = S_FIND_LD;
        end
      end
      S_FIND_LD: begin
        cmd.cur_sel = pblct_pkg::CUR_LINK;
        state_next  = S_FIND_CHK;
      end
      S_DEL_HRD: begin
        state_next = S_DEL_HWR;
      end
      S_DEL_HWR: begin
        cmd.head_we = 1'b1;
        cmd.head_wd = pblct_pkg::HW_LINK;
        cmd.hq_sel  = pblct_pkg::HQ_LINK;
        cmd.link_we = 1'b1;
        cmd.link_wa = pblct_pkg::LA_ID;
        cmd.link_wd = pblct_pkg::LD_ZERO;
        state_next  = S_FIN;
      end
      S_DEL_RD: begin
        state_next = S_DEL_CHK;
      end
      // the check at the bound still counts a match
      S_DEL_CHK: begin
        if (sts.link_eq_id) begin
          state_next = S_DEL_IDRD;
        end else if (sts.link_zero || sts.n_full) begin
          state_next = S_FIN;
        end else begin
          cmd.cur_sel = pblct_pkg::CUR_LINK;
          cmd.n_op    = pblct_pkg::N_INC;
          state_next  = S_DEL_RD;
        end
      end
      S_DEL_IDRD: begin
        cmd.raddr_id = 1'b1;
        state_next   = S_DEL_FIX;
      end
      S_DEL_FIX: begin
        cmd.link_we = 1'b1;
        cmd.link_wa = pblct_pkg::LA_CUR;
        cmd.link_wd = pblct_pkg::LD_LINK;
        state_next  = S_DEL_CLR;
      end
      S_DEL_CLR: begin
        cmd.link_we = 1'b1;
        cmd.link_wa = pblct_pkg::LA_ID;
        cmd.link_wd = pblct_pkg::LD_ZERO;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/per_bucket_linked_chain_table.sv =====
// Per-bucket linked chain table: one chain of object ids per tile.
// Input beat: s_tuser = func; s_tdata = tile, object_id. Output beat: m_tdata =
// position, head_id, occupied; m_tuser = status (1 = tile out of range).
// One result beat per input beat, in order. Items are handled one at a time;
// s_tready is high only while the controller waits for work.
// Out-of-range tiles go straight to the result register; query, add to an empty
// tile and delete on an empty tile or of id none finish after the head read; find
// and add walk the chain link by link; delete of the head rewrites the head entry;
// other deletes walk, then unlink. The walk rate is set by the registered read port
// of the link memory; the next beat can be taken in the cycle after the result is
// loaded.
// After reset both tables are zeroed by a clearing pass over
// max(TILE_COUNT, OBJECT_SLOTS) addresses (32768 by default); no beat is taken
// during it. A finished result sits in the output register while the next
// beat is accepted; if m_tready stays low, the following item waits at its
// end until the register frees up.
// Depends on pblct_pkg, pblct_ctrl and pblct_datapath.
`default_nettype none

module per_bucket_linked_chain_table #(
  parameter int TILE_COUNT   = 32768,
  parameter int OBJECT_SLOTS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [pblct_pkg::IN_DATA_W-1:0]    s_tdata,   // tile[15:0], object_id[25:16]
  input  wire logic [pblct_pkg::FUNC_W-1:0]       s_tuser,   // func[1:0]
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [pblct_pkg::OUT_DATA_W-1:0]        m_tdata,   // position[4:0], head_id[14:5],
                                                             // occupied[15]
  output logic                                    m_tuser    // status[0]
);

  pblct_pkg::cmd_t cmd;
  pblct_pkg::sts_t sts;

  pblct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pblct_datapath #(
    .TILE_COUNT   (TILE_COUNT),
    .OBJECT_SLOTS (OBJECT_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== src/pblct_checker.sv =====
// Port checker for per_bucket_linked_chain_table, bound to the top level.
// Depends on pblct_pkg for field widths and the position cap.
`default_nettype none

module pblct_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [pblct_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic                               m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed under stall");

  // one item in flight: no beat taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken back to back");

  a_bad_tile_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out-of-range tile result carries data");

  a_occupied: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15] == (m_tdata[14:5] != '0))
    else $error("occupied flag disagrees with head_id");

  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= pblct_pkg::POSITION_CAP)
    else $error("position above cap");

endmodule

bind per_bucket_linked_chain_table pblct_checker u_pblct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
